@@ src/bnqs_pkg.sv @@
// ----------------------------------------------------------------------------
// bnqs_pkg: shared types and constants of the buzzer note queue sequencer
// opcodes, note record and fixed field widths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bnqs_pkg;

  localparam int unsigned HzW   = 16;
  localparam int unsigned MsW   = 16;
  localparam int unsigned GapW  = 8;
  localparam int unsigned WaitW = 4;

  // reset value of the gap register
  localparam logic [GapW-1:0] GapReset = 8'd12;

  // input tdata: note_hz, note_ms
  localparam int unsigned InDataW  = 32;
  // input tuser: op, first_of_tune
  localparam int unsigned InUserW  = 3;
  // output tdata: tone_hz, tone_ms, busy_res, waiting, zero fill
  localparam int unsigned OutDataW = 40;
  // output tuser: tone_start, tone_stop, accepted
  localparam int unsigned OutUserW = 3;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_TUNE    = 2'd1,
    OP_NOW     = 2'd2,
    OP_SILENCE = 2'd3
  } op_e;

  typedef struct packed {
    logic [HzW-1:0] hz;
    logic [MsW-1:0] ms;
  } note_t;

  // control of one queue cell
  typedef struct packed {
    logic shift;  // take the note of the next cell down the row
    logic load;   // take the appended note
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/bnqs_cell.sv @@
// ----------------------------------------------------------------------------
// bnqs_cell: one entry of the note queue
// holds a note; loads an appended note or takes its neighbor's on a pop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bnqs_cell (
  input  wire                     clk_i,
  input  bnqs_pkg::cell_ctl_t     ctl_i,
  input  bnqs_pkg::note_t         load_note_i,
  input  bnqs_pkg::note_t         next_note_i,
  output bnqs_pkg::note_t         note_o
);
  import bnqs_pkg::*;

  note_t note_q;
  note_t note_d;

  always_comb begin
    note_d = note_q;
    if (ctl_i.shift) begin
      note_d = next_note_i;
    end else if (ctl_i.load) begin
      note_d = load_note_i;
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
  end

  assign note_o = note_q;

endmodule

`default_nettype wire

@@ src/buzzer_note_queue_sequencer.sv @@
// ----------------------------------------------------------------------------
// buzzer_note_queue_sequencer: plays a tune by queueing notes for a buzzer
// Every input beat is a one-millisecond tick, a tune note, an immediate note
// or a silence command, and every input beat gives exactly one output beat.
// A first tune note or an immediate note clears the queue and starts at once;
// later tune notes append to a row of QUEUE_DEPTH cells and are dropped with
// accepted low when the row is full. A started note issues tone_start with
// its pitch and an audible length of the slot minus gap_ms (the whole slot
// when it is not longer than the gap); a zero pitch issues tone_stop instead.
// Ticks count the slot down and start the head note of the queue when the
// slot ends; a zero-length slot ends on the next tick. The block takes one
// beat per clock: the work of a beat is done in the cycle it is accepted and
// lands in a single output register, so the input stalls only while that
// register holds a beat the consumer has not taken. The queue is a chain of
// cells that all shift one place toward the head when the head note starts.
// gap_ms sits at byte address 0 of the register port, reset value 12.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buzzer_note_queue_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 12
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // input stream
  input  wire                               s_tvalid_i,
  output logic                              s_tready_o,
  input  wire  [bnqs_pkg::InDataW-1:0]      s_tdata_i,   // note_hz, note_ms
  input  wire  [bnqs_pkg::InUserW-1:0]      s_tuser_i,   // op, first_of_tune
  // output stream
  output logic                              m_tvalid_o,
  input  wire                               m_tready_i,
  // tone_hz, tone_ms, busy_res, waiting, zero fill
  output logic [bnqs_pkg::OutDataW-1:0]     m_tdata_o,
  output logic [bnqs_pkg::OutUserW-1:0]     m_tuser_o,   // tone_start, tone_stop, accepted
  // register port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [2:0]                        paddr,
  input  wire  [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import bnqs_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  // ---------------------------------------------------------------- registers
  logic [GapW-1:0] gap_q;
  logic [CntW-1:0] count_q, count_d;
  logic [MsW-1:0]  slot_q, slot_d;
  logic            sounding_q, sounding_d;
  logic            out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [OutUserW-1:0] out_user_q, out_user_d;

  // ---------------------------------------------------------- register port
  assign pready = 1'b1;
  // only register index 0 exists; just paddr[2] is decoded, so addresses 0 to 3 read gap_ms and 4 to 7 read as zero
  assign prdata = (paddr[2] == 1'b0) ? {{(32-GapW){1'b0}}, gap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= GapReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      gap_q <= pwdata[GapW-1:0];
    end
  end

  // ------------------------------------------------------------ input decode
  op_e             in_op;
  logic            in_first;
  note_t           in_note;
  logic            in_accept;

  assign in_op       = op_e'(s_tuser_i[1:0]);
  assign in_first    = s_tuser_i[2];
  assign in_note.hz  = s_tdata_i[HzW-1:0];
  assign in_note.ms  = s_tdata_i[HzW+MsW-1:HzW];
  assign s_tready_o  = !out_valid_q || m_tready_i;
  assign in_accept   = s_tvalid_i && s_tready_o;

  // --------------------------------------------------------- queue of cells
  note_t     cell_note [QUEUE_DEPTH];
  cell_ctl_t cell_ctl  [QUEUE_DEPTH];
  logic      pop;      // head note starts, the row moves one place
  logic      append;   // tune note goes to the first free cell

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    note_t next_note;
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_note = '0;
    end else begin : g_mid
      assign next_note = cell_note[i+1];
    end
    assign cell_ctl[i].shift = in_accept && pop;
    assign cell_ctl[i].load  = in_accept && append && (count_q == CntW'(i));

    bnqs_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl[i]),
      .load_note_i (in_note),
      .next_note_i (next_note),
      .note_o      (cell_note[i])
    );
  end

  // ---------------------------------------------------------- step logic
  note_t           start_note;   // note begun by this beat
  logic            start_en;
  logic            tone_start, tone_stop, acc;
  logic [MsW-1:0]  tone_ms_w;
  logic [MsW-1:0]  gap_ext;

  assign gap_ext = {{(MsW-GapW){1'b0}}, gap_q};

  always_comb begin
    count_d    = count_q;
    slot_d     = slot_q;
    sounding_d = sounding_q;
    pop        = 1'b0;
    append     = 1'b0;
    start_en   = 1'b0;
    start_note = in_note;
    tone_stop  = 1'b0;
    acc        = 1'b1;

    case (in_op)
      OP_TICK: begin
        if (sounding_q) begin
          if (slot_q > MsW'(1)) begin
            slot_d = slot_q - MsW'(1);
          end else if (count_q != '0) begin
            pop        = 1'b1;
            count_d    = count_q - CntW'(1);
            start_en   = 1'b1;
            start_note = cell_note[0];
          end else begin
            slot_d     = '0;
            sounding_d = 1'b0;
          end
        end
      end
      OP_TUNE: begin
        if (in_first) begin
          count_d  = '0;
          start_en = 1'b1;
        end else if (count_q < CntW'(QUEUE_DEPTH)) begin
          append  = 1'b1;
          count_d = count_q + CntW'(1);
        end else begin
          acc = 1'b0;
        end
      end
      OP_NOW: begin
        count_d  = '0;
        start_en = 1'b1;
      end
      OP_SILENCE: begin
        count_d    = '0;
        sounding_d = 1'b0;
        slot_d     = '0;
        tone_stop  = 1'b1;
      end
      default: begin
        acc = 1'b1;
      end
    endcase

    // starting a note: rest pitch silences the buzzer instead of a tone
    tone_start = 1'b0;
    if (start_en) begin
      slot_d     = start_note.ms;
      sounding_d = 1'b1;
      if (start_note.hz != '0) begin
        tone_start = 1'b1;
      end else begin
        tone_stop = 1'b1;
      end
    end
  end

  // audible length, the slot minus the gap when the slot is longer
  assign tone_ms_w = (start_note.ms > gap_ext) ? (start_note.ms - gap_ext) : start_note.ms;

  always_comb begin
    out_data_d = '0;
    out_data_d[HzW-1:0]                     = tone_start ? start_note.hz : '0;
    out_data_d[HzW+MsW-1:HzW]               = tone_start ? tone_ms_w : '0;
    out_data_d[HzW+MsW]                     = sounding_d;
    out_data_d[HzW+MsW+WaitW:HzW+MsW+1]     = WaitW'(count_d);
    out_user_d = {acc, tone_stop, tone_start};
  end

  // ------------------------------------------------------ state and output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      slot_q      <= '0;
      sounding_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        count_q    <= count_d;
        slot_q     <= slot_d;
        sounding_q <= sounding_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;

  // ------------------------------------------------------------- assertions
`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("queue fill beyond depth");

  a_slot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sounding_q |-> (slot_q == '0))
    else $error("slot counter running while no note sounds");

  a_start_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> !(m_tuser_o[0] && m_tuser_o[1]))
    else $error("tone start and stop in one beat");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_op == OP_TICK) && !sounding_q) |=>
      (count_q == $past(count_q)) && !sounding_q)
    else $error("tick while idle changed the queue");
`endif

endmodule

`default_nettype wire

@@ tb/buzzer_note_queue_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// buzzer_note_queue_sequencer_tb: self-checking bench of the note sequencer
// Drives ticks, tune notes, immediate notes and silence commands over the
// input stream and predicts every output beat with a behavioral model of the
// note queue, slot counter and gap trimming. Runs a directed opening and then
// phases of random tunes under several gap settings and idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module buzzer_note_queue_sequencer_tb;

  import bnqs_pkg::*;

  localparam int unsigned QueueDepth = 12;
  localparam logic [2:0]  GapAddr    = 3'd0;     // gap_ms register
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseBeats = 170;
  localparam int unsigned NumPhases  = 8;

  // one output beat split into its fields
  typedef struct packed {
    logic           start;
    logic           stop;
    logic [HzW-1:0] hz;
    logic [MsW-1:0] ms;
    logic           busy;
    logic [WaitW-1:0] waiting;
    logic           acc;
  } tone_res_t;

  // ---------------------------------------------------------------------------
  // behavioral model of the sequencer plus the store of predicted beats
  // ---------------------------------------------------------------------------
  class tone_scoreboard;
    note_t       tune_q[$];      // notes waiting behind the sounding one
    logic [15:0] slot_left;
    bit          sounding;
    logic [7:0]  gap;
    tone_res_t   pending_tones[$];
    int unsigned mismatches;

    function new();
      slot_left  = '0;
      sounding   = 1'b0;
      gap        = GapReset;
      mismatches = 0;
    endfunction

    function void set_gap(logic [7:0] value);
      gap = value;
    endfunction

    // a zero pitch silences the buzzer but still occupies the slot
    function void start_note(input note_t n, inout tone_res_t r);
      if (n.hz != '0) begin
        r.start = 1'b1;
        r.hz    = n.hz;
        r.ms    = (n.ms > gap) ? n.ms - gap : n.ms;
      end else begin
        r.stop = 1'b1;
      end
      slot_left = n.ms;
      sounding  = 1'b1;
    endfunction

    function void note_beat(op_e op, logic [15:0] hz, logic [15:0] ms, logic first);
      tone_res_t r;
      note_t     n;
      r     = '0;
      r.acc = 1'b1;
      n.hz  = hz;
      n.ms  = ms;
      case (op)
        OP_TICK: begin
          // ticks do nothing while idle
          if (sounding) begin
            if (slot_left > 16'd1) begin
              slot_left--;
            end else if (tune_q.size() > 0) begin
              start_note(tune_q.pop_front(), r);
            end else begin
              // tone already ended by its own length, no stop
              slot_left = '0;
              sounding  = 1'b0;
            end
          end
        end
        OP_TUNE: begin
          if (first) begin
            tune_q.delete();
            start_note(n, r);
          end else if (tune_q.size() < QueueDepth) begin
            tune_q.push_back(n);
          end else begin
            r.acc = 1'b0;   // queue full, note dropped
          end
        end
        OP_NOW: begin
          tune_q.delete();
          start_note(n, r);
        end
        default: begin
          tune_q.delete();
          sounding  = 1'b0;
          slot_left = '0;
          r.stop    = 1'b1;
        end
      endcase
      r.busy    = sounding;
      r.waiting = WaitW'(tune_q.size());
      pending_tones.push_back(r);
    endfunction

    function void report(string field, logic [15:0] want, logic [15:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_beat(tone_res_t got);
      tone_res_t want;
      if (pending_tones.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("output beat with nothing predicted: %p", got);
        return;
      end
      want = pending_tones.pop_front();
      if (got.start   !== want.start)   report("tone_start", want.start, got.start);
      if (got.stop    !== want.stop)    report("tone_stop", want.stop, got.stop);
      if (got.hz      !== want.hz)      report("tone_hz", want.hz, got.hz);
      if (got.ms      !== want.ms)      report("tone_ms", want.ms, got.ms);
      if (got.busy    !== want.busy)    report("busy_res", want.busy, got.busy);
      if (got.waiting !== want.waiting) report("waiting", want.waiting, got.waiting);
      if (got.acc     !== want.acc)     report("accepted", want.acc, got.acc);
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // clock, block inputs and the device
  // ---------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni     = 1'b0;
  logic                s_tvalid_i = 1'b0;
  logic                s_tready_o;
  logic [InDataW-1:0]  s_tdata_i  = '0;   // note_hz, note_ms
  logic [InUserW-1:0]  s_tuser_i  = '0;   // op, first_of_tune
  logic                m_tvalid_o;
  logic                m_tready_i = 1'b0;
  logic [OutDataW-1:0] m_tdata_o;         // tone_hz, tone_ms, busy_res, waiting, zero fill
  logic [OutUserW-1:0] m_tuser_o;         // tone_start, tone_stop, accepted
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [2:0]          paddr      = '0;
  logic [31:0]         pwdata     = '0;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles         = 0;

  tone_scoreboard sb = new();

  buzzer_note_queue_sequencer #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver stalls at random, one decision per edge
  always @(posedge clk_i) begin
    m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // output monitor: values read here are the ones from before the edge
  always @(posedge clk_i) begin
    tone_res_t got;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got.hz      = m_tdata_o[15:0];
      got.ms      = m_tdata_o[31:16];
      got.busy    = m_tdata_o[32];
      got.waiting = m_tdata_o[36:33];
      got.start   = m_tuser_o[0];
      got.stop    = m_tuser_o[1];
      got.acc     = m_tuser_o[2];
      sb.check_beat(got);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("buzzer_note_queue_sequencer test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one input beat; valid stays high from one beat to the next unless idling
  task automatic send_beat(op_e op, logic [15:0] hz, logic [15:0] ms, logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {ms, hz};
    s_tuser_i  <= {first, op};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_beat(op, hz, ms, first);
  endtask

  // setup cycle, then access cycle; pready is always high
  task automatic write_gap(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GapAddr;
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_gap(value);
  endtask

  // stop sending and let every predicted beat come out
  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending_tones.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // slot lengths: mostly a few ms so queues play through, sometimes near the gap
  function automatic logic [15:0] rand_ms();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 80) return 16'($urandom_range(6));
    if (pick < 95) return 16'($urandom_range(300));
    return 16'($urandom);
  endfunction

  // pitches: some rests, the rest over the whole range
  function automatic logic [15:0] rand_hz();
    if ($urandom_range(9) == 0) return '0;
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0]  gap_plan [NumPhases];
    int unsigned sent;
    int unsigned pick;
    int unsigned n_notes;

    gap_plan = '{8'd0, 8'd255, 8'd12, 8'($urandom), 8'd1, 8'd255, 8'd0, 8'($urandom)};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed opening, reset gap of 12
    // orphan notes pile up while idle until the queue overflows
    for (int i = 0; i < 13; i++) send_beat(OP_TUNE, 16'(i * 5000 + 1), 16'(i), 1'b0);
    send_beat(OP_TUNE, 16'd440, 16'd1, 1'b1);      // restart clears the orphans
    send_beat(OP_TUNE, 16'd0, 16'd2, 1'b0);        // rest
    send_beat(OP_TUNE, 16'hffff, 16'd1, 1'b0);     // top pitch, slot shorter than gap
    send_beat(OP_TUNE, 16'd1, 16'd0, 1'b0);        // zero-length slot
    send_beat(OP_TUNE, 16'd300, 16'd13, 1'b0);     // one above the gap
    repeat (5) send_beat(OP_TICK, 16'd0, 16'd0, 1'b0);
    send_beat(OP_NOW, 16'd700, 16'd12, 1'b0);      // slot equal to gap
    send_beat(OP_NOW, 16'hffff, 16'hffff, 1'b1);   // longest slot
    send_beat(OP_NOW, 16'd0, 16'hffff, 1'b0);      // immediate rest
    send_beat(OP_SILENCE, 16'hffff, 16'hffff, 1'b1);
    send_beat(OP_TICK, 16'hffff, 16'hffff, 1'b1);  // tick while idle
    drain();

    // random phases, each with its own gap and idling pattern
    for (int p = 0; p < NumPhases; p++) begin
      write_gap(gap_plan[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      sent = 0;
      while (sent < PhaseBeats) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          // well-formed tune, sometimes long enough to overflow the queue
          n_notes = $urandom_range(15);
          send_beat(OP_TUNE, rand_hz(), rand_ms(), 1'b1);
          for (int i = 0; i < n_notes; i++) send_beat(OP_TUNE, rand_hz(), rand_ms(), 1'b0);
          pick = $urandom_range(40);
          for (int i = 0; i < pick; i++)
            send_beat(OP_TICK, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
          sent += 1 + n_notes + pick;
        end else if (pick < 80) begin
          send_beat(OP_NOW, rand_hz(), rand_ms(), 1'($urandom_range(1)));
          pick = $urandom_range(8);
          for (int i = 0; i < pick; i++) send_beat(OP_TICK, 16'($urandom), 16'($urandom), 1'b0);
          sent += 1 + pick;
        end else if (pick < 87) begin
          send_beat(OP_SILENCE, 16'($urandom), 16'($urandom), 1'($urandom_range(1)));
          sent++;
        end else begin
          // noise, every field fully random
          send_beat(op_e'($urandom_range(3)), 16'($urandom), 16'($urandom),
                    1'($urandom_range(1)));
          sent++;
        end
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_tones.size() == 0) begin
      $display("buzzer_note_queue_sequencer test passed");
    end else begin
      $display("buzzer_note_queue_sequencer test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
